[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every rising clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[rtl/grpc_pkg.sv]
// Shared constants and types for the grid radius point counter.
`timescale 1ns / 1ps
package grpc_pkg;

  localparam int COORD_W       = 24;
  localparam int RADIUS_W      = 24;
  localparam int COUNT_W       = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int MAX_POINTS_DEF = 4096;
  localparam int CELL_SIZE_DEF  = 10;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // status of the classified-item queue
  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

endpackage

[rtl/grpc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module grpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/grpc_fifo.sv]
// Two-entry queue between the classifier front end and the store back end.
`timescale 1ns / 1ps
module grpc_fifo #(
  parameter int W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [W-1:0]       din,
  input  logic               pop,
  output logic [W-1:0]       dout,
  output grpc_pkg::q_flags_t flags
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;
  logic         do_push;
  logic         do_pop;

  assign flags.full  = (cnt_r == 2'd2);
  assign flags.empty = (cnt_r == 2'd0);
  assign do_push     = push && !flags.full;
  assign do_pop      = pop && !flags.empty;
  assign dout        = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

[rtl/grpc_front.sv]
// Front end: accepts input beats and works out the grid cell of each point.
`timescale 1ns / 1ps
module grpc_front #(
  parameter int CELL_SIZE = grpc_pkg::CELL_SIZE_DEF,
  localparam int CW = grpc_pkg::COORD_W,
  localparam int CELL_W = $clog2((2 ** (grpc_pkg::COORD_W - 1)) / CELL_SIZE + 1) + 1,
  localparam int ITEM_W = 1 + 2 * grpc_pkg::COORD_W + grpc_pkg::RADIUS_W + 2 * CELL_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic                             in_command,
  input  logic signed [CW-1:0]             in_coord_x,
  input  logic signed [CW-1:0]             in_coord_y,
  input  logic [grpc_pkg::RADIUS_W-1:0]    in_radius,
  output logic                             q_push,
  output logic [ITEM_W-1:0]                q_data,
  input  grpc_pkg::q_flags_t               q_flags
);

  // reciprocal of the cell size, scaled by 2^CW; one correction step fixes the quotient
  localparam logic [CW:0]  RECIP = (CW + 1)'((2 ** CW) / CELL_SIZE);
  localparam logic [16:0]  CSZ   = 17'(CELL_SIZE);
  localparam int           MW    = CW + 17;

  typedef enum logic [3:0] {
    FR_IDLE = 4'b0001,
    FR_MUL  = 4'b0010,
    FR_DIV  = 4'b0100,
    FR_PUSH = 4'b1000
  } fr_state_t;

  fr_state_t                      st_r, st_nxt;
  logic                           cmd_r;
  logic [CW-1:0]                  x_r, y_r;
  logic [grpc_pkg::RADIUS_W-1:0]  rad_r;
  logic [CW-1:0]                  ax_r, ay_r;
  logic [CW-1:0]                  qx_r, qy_r;
  logic [CELL_W-1:0]              cx_r, cy_r;

  logic [CW-1:0]        in_x_u, in_y_u, ax, ay;
  logic [2*CW:0]        px, py;
  logic [MW-1:0]        mx, my, rx, ry;
  logic [CW-1:0]        qcx, qcy;
  logic [CELL_W-1:0]    qwx, qwy, cell_x, cell_y;
  logic                 accept;

  assign full   = (st_r != FR_IDLE);
  assign accept = push && !full;
  assign in_x_u = in_coord_x;
  assign in_y_u = in_coord_y;
  assign ax     = in_x_u[CW-1] ? (~in_x_u + 1'b1) : in_x_u;
  assign ay     = in_y_u[CW-1] ? (~in_y_u + 1'b1) : in_y_u;

  assign px = (2*CW+1)'(ax_r) * (2*CW+1)'(RECIP);
  assign py = (2*CW+1)'(ay_r) * (2*CW+1)'(RECIP);

  // remainder check: the estimate is low by at most one
  assign mx  = MW'(qx_r) * MW'(CSZ);
  assign my  = MW'(qy_r) * MW'(CSZ);
  assign rx  = MW'(ax_r) - mx;
  assign ry  = MW'(ay_r) - my;
  assign qcx = (rx >= MW'(CSZ)) ? qx_r + 1'b1 : qx_r;
  assign qcy = (ry >= MW'(CSZ)) ? qy_r + 1'b1 : qy_r;
  assign qwx = CELL_W'(qcx);
  assign qwy = CELL_W'(qcy);
  // truncation toward zero: negate the magnitude quotient
  assign cell_x = x_r[CW-1] ? (~qwx + 1'b1) : qwx;
  assign cell_y = y_r[CW-1] ? (~qwy + 1'b1) : qwy;

  assign q_push = (st_r == FR_PUSH) && !q_flags.full;
  assign q_data = {cmd_r, x_r, y_r, rad_r, cx_r, cy_r};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      FR_IDLE: if (accept) st_nxt = FR_MUL;
      FR_MUL:  st_nxt = FR_DIV;
      FR_DIV:  st_nxt = FR_PUSH;
      FR_PUSH: if (!q_flags.full) st_nxt = FR_IDLE;
      default: st_nxt = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FR_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      x_r   <= in_x_u;
      y_r   <= in_y_u;
      rad_r <= in_radius;
      ax_r  <= ax;
      ay_r  <= ay;
    end
    if (st_r == FR_MUL) begin
      qx_r <= px[2*CW-1:CW];
      qy_r <= py[2*CW-1:CW];
    end
    if (st_r == FR_DIV) begin
      cx_r <= cell_x;
      cy_r <= cell_y;
    end
  end

endmodule

[rtl/grpc_back.sv]
// Back end: point store, query scan pipeline and result register.
`timescale 1ns / 1ps
module grpc_back #(
  parameter int MAX_POINTS = grpc_pkg::MAX_POINTS_DEF,
  parameter int CELL_SIZE  = grpc_pkg::CELL_SIZE_DEF,
  localparam int CW = grpc_pkg::COORD_W,
  localparam int RW = grpc_pkg::RADIUS_W,
  localparam int NW = grpc_pkg::COUNT_W,
  localparam int CELL_W = $clog2((2 ** (grpc_pkg::COORD_W - 1)) / CELL_SIZE + 1) + 1,
  localparam int ITEM_W = 1 + 2 * grpc_pkg::COORD_W + grpc_pkg::RADIUS_W + 2 * CELL_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [ITEM_W-1:0]  q_data,
  input  grpc_pkg::q_flags_t q_flags,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic [NW-1:0]      out_match_count
);

  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int TW    = $clog2(MAX_POINTS + 1);
  localparam int MEM_W = 2 * CW + 2 * CELL_W;
  localparam int SQ_W  = 2 * CW;

  typedef enum logic [2:0] {
    BK_IDLE   = 3'b001,
    BK_SCAN   = 3'b010,
    BK_RESULT = 3'b100
  } bk_state_t;

  bk_state_t          st_r, st_nxt;
  logic [TW-1:0]      total_r;
  logic [TW-1:0]      idx_r;
  logic [CW-1:0]      qx_r, qy_r;
  logic [CELL_W-1:0]  qcx_r, qcy_r;
  logic [2*RW-1:0]    r2_r;
  logic               p1_v_r, p2_v_r, p3_v_r;
  logic               p2_ok_r, p3_ok_r;
  logic [CW-1:0]      dx_r, dy_r;
  logic [SQ_W-1:0]    dx2_r, dy2_r;
  logic [NW-1:0]      cnt_r;
  logic               out_valid_r;
  logic [NW-1:0]      out_cnt_r;

  // queue item fields
  logic               it_cmd;
  logic [CW-1:0]      it_x, it_y;
  logic [RW-1:0]      it_rad;
  logic [CELL_W-1:0]  it_cx, it_cy;

  logic               wr_en, issue, drained, hit;
  logic [MEM_W-1:0]   rd_data;
  logic [CW-1:0]      sx, sy;
  logic [CELL_W-1:0]  scx, scy;
  logic [CELL_W:0]    dcx, dcy;
  logic [CW:0]        dxs, dys;
  logic [SQ_W:0]      dist2;
  logic               cell_ok;

  assign {it_cmd, it_x, it_y, it_rad, it_cx, it_cy} = q_data;

  assign q_pop   = (st_r == BK_IDLE) && !q_flags.empty;
  assign wr_en   = q_pop && (it_cmd == grpc_pkg::CMD_INSERT) && (total_r < TW'(MAX_POINTS));
  assign issue   = (st_r == BK_SCAN) && (idx_r != total_r);
  assign drained = (idx_r == total_r) && !p1_v_r && !p2_v_r && !p3_v_r;

  grpc_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (total_r[AW-1:0]),
    .wr_data ({it_x, it_y, it_cx, it_cy}),
    .rd_en   (issue),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  // stage 1: cell window check and absolute coordinate differences
  assign {sx, sy, scx, scy} = rd_data;
  assign dcx = {scx[CELL_W-1], scx} - {qcx_r[CELL_W-1], qcx_r};
  assign dcy = {scy[CELL_W-1], scy} - {qcy_r[CELL_W-1], qcy_r};
  assign cell_ok = (dcx == '0 || dcx == (CELL_W+1)'(1) || dcx == '1) &&
                   (dcy == '0 || dcy == (CELL_W+1)'(1) || dcy == '1);
  assign dxs = {sx[CW-1], sx} - {qx_r[CW-1], qx_r};
  assign dys = {sy[CW-1], sy} - {qy_r[CW-1], qy_r};

  // stage 3: distance compare
  assign dist2 = (SQ_W+1)'(dx2_r) + (SQ_W+1)'(dy2_r);
  assign hit   = p3_v_r && p3_ok_r && (dist2 <= (SQ_W+1)'(r2_r));

  assign empty           = !out_valid_r;
  assign out_match_count = out_cnt_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE:   if (q_pop && it_cmd == grpc_pkg::CMD_QUERY) st_nxt = BK_SCAN;
      BK_SCAN:   if (drained) st_nxt = BK_RESULT;
      BK_RESULT: if (!out_valid_r) st_nxt = BK_IDLE;
      default:   st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      total_r     <= '0;
      idx_r       <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      p1_v_r <= issue;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      if (wr_en) total_r <= total_r + 1'b1;
      if (q_pop && it_cmd == grpc_pkg::CMD_QUERY) begin
        idx_r <= '0;
        cnt_r <= '0;
      end else begin
        if (issue) idx_r <= idx_r + 1'b1;
        if (hit && cnt_r != grpc_pkg::COUNT_MAX) cnt_r <= cnt_r + 1'b1;
      end
      if (st_r == BK_RESULT && !out_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && it_cmd == grpc_pkg::CMD_QUERY) begin
      qx_r  <= it_x;
      qy_r  <= it_y;
      qcx_r <= it_cx;
      qcy_r <= it_cy;
      r2_r  <= (2*RW)'(it_rad) * (2*RW)'(it_rad);
    end
    p2_ok_r <= cell_ok;
    dx_r    <= dxs[CW] ? CW'(-dxs) : dxs[CW-1:0];
    dy_r    <= dys[CW] ? CW'(-dys) : dys[CW-1:0];
    p3_ok_r <= p2_ok_r;
    dx2_r   <= SQ_W'(dx_r) * SQ_W'(dx_r);
    dy2_r   <= SQ_W'(dy_r) * SQ_W'(dy_r);
    if (st_r == BK_RESULT && !out_valid_r) begin
      out_cnt_r <= cnt_r;
    end
  end

endmodule

[rtl/grid_radius_point_count_core.sv]
// Top level of the grid radius point counter: front end, queue and point store.
`timescale 1ns / 1ps
// Stores 2D points and answers radius-count queries. A beat with command 0
// inserts (coord_x, coord_y) with its grid cell (each coordinate divided by
// CELL_SIZE, truncated toward zero); inserts past MAX_POINTS are dropped and
// no insert gives a result. A beat with command 1 gives one result beat:
// the count of stored points whose cell is within one cell of the query's
// cell on both axes and whose squared distance is at most radius squared,
// saturating at 8191. The front end steps each beat through register, scaled
// reciprocal multiply, remainder correction and queue push (which waits while
// the queue is full), holding full high meanwhile. A two-entry queue decouples
// it from the back end. In the back end an insert is stored as it is popped; a
// query scans the point store's single read port one entry per cycle through a
// compare pipeline. The result sits in an output register, so the back end keeps
// taking inserts while it waits; a second query is scanned, but its result holds
// until the previous result is popped.
module grid_radius_point_count_core #(
  parameter int MAX_POINTS = grpc_pkg::MAX_POINTS_DEF,
  parameter int CELL_SIZE  = grpc_pkg::CELL_SIZE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   in_command,
  input  logic signed [grpc_pkg::COORD_W-1:0]    in_coord_x,
  input  logic signed [grpc_pkg::COORD_W-1:0]    in_coord_y,
  input  logic [grpc_pkg::RADIUS_W-1:0]          in_radius,
  output logic                                   empty,
  input  logic                                   pop,
  output logic [grpc_pkg::COUNT_W-1:0]           out_match_count
);

`include "assert_macros.svh"

  // cell width follows from the coordinate range and the cell size
  localparam int CELL_W = $clog2((2 ** (grpc_pkg::COORD_W - 1)) / CELL_SIZE + 1) + 1;
  localparam int ITEM_W = 1 + 2 * grpc_pkg::COORD_W + grpc_pkg::RADIUS_W + 2 * CELL_W;

  logic               q_push;
  logic               q_pop;
  logic [ITEM_W-1:0]  q_din;
  logic [ITEM_W-1:0]  q_dout;
  grpc_pkg::q_flags_t q_flags;

  // front end: takes input beats, computes cells
  grpc_front #(
    .CELL_SIZE (CELL_SIZE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_command (in_command),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .in_radius  (in_radius),
    .q_push     (q_push),
    .q_data     (q_din),
    .q_flags    (q_flags)
  );

  // classified items wait here
  grpc_fifo #(
    .W (ITEM_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .flags (q_flags)
  );

  // back end: store, scan, result register
  grpc_back #(
    .MAX_POINTS (MAX_POINTS),
    .CELL_SIZE  (CELL_SIZE)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_data          (q_dout),
    .q_flags         (q_flags),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_match_count (out_match_count)
  );

  // queue flags agree with each other
  `ASSERT_ALWAYS(a_q_flags_consistent, clk, rst_n, !(q_flags.full && q_flags.empty))
  // front end never pushes into a full queue
  `ASSERT_IMPLIES(a_no_push_when_full, clk, rst_n, q_push, !q_flags.full)
  // back end never pops an empty queue
  `ASSERT_IMPLIES(a_no_pop_when_empty, clk, rst_n, q_pop, !q_flags.empty)

endmodule
